>>> design/abt_pkg.sv
// Shared types, codes and default sizes for the allocation bounds tracker.
package abt_pkg;

  localparam int unsigned REGION_ENTRIES_DEF = 16;
  localparam int unsigned MOVE_ENTRIES_DEF   = 16;
  localparam int unsigned ADDR_BITS_DEF      = 48;
  localparam int unsigned SIZE_BITS_DEF      = 32;
  localparam int unsigned OUT_ADDR_BITS      = 48;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_CHECK  = 2'd1,
    ACT_GROW   = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_ALLOC_FAIL = 3'd3,
    ST_FULL       = 3'd4,
    ST_BAD_OFFSET = 3'd5
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EVAL = 1'b1
  } fsm_e;

  // Flags that ripple from cell to cell along the region row.
  typedef struct packed {
    logic base_seen;
    logic nbase_seen;
    logic free_seen;
    logic in_seen;
  } reg_chain_t;

  // Controls broadcast to every region cell.
  typedef struct packed {
    logic rec_go;
    logic grow_go;
    logic any_base;
    logic any_nbase;
  } reg_ctl_t;

  // Flags that ripple along the relocation row.
  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } move_chain_t;

  // Controls broadcast to every relocation cell.
  typedef struct packed {
    logic wr_go;
    logic any_hit;
  } move_ctl_t;

endpackage

>>> design/abt_region_cell.sv
// One region table entry with its local match, bounds and write logic.
module abt_region_cell #(
  parameter int unsigned ADDR_BITS = abt_pkg::ADDR_BITS_DEF,
  parameter int unsigned SIZE_BITS = abt_pkg::SIZE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ADDR_BITS-1:0]   base_i,
  input  logic [ADDR_BITS-1:0]   nbase_i,
  input  logic [ADDR_BITS-1:0]   addr_i,
  input  logic [SIZE_BITS-1:0]   acc_size_i,
  input  logic [ADDR_BITS-1:0]   wr_start_i,
  input  logic [SIZE_BITS-1:0]   wr_size_i,
  input  abt_pkg::reg_ctl_t      ctl_i,
  input  abt_pkg::reg_chain_t    chain_i,
  output abt_pkg::reg_chain_t    chain_o
);
  import abt_pkg::*;

  localparam int unsigned CW = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 1;

  logic [ADDR_BITS-1:0] start_q;
  logic [SIZE_BITS-1:0] size_q;
  logic                 used_q;

  logic                 hit_base, hit_nbase, is_free;
  logic                 sel_base, sel_nbase, sel_free;
  logic [ADDR_BITS-1:0] off;
  logic [CW-1:0]        span, lim;
  logic                 in_here, wr_en, clr_en;

  always_comb begin
    hit_base  = used_q && (start_q == base_i);
    hit_nbase = used_q && (start_q == nbase_i);
    is_free   = !used_q;
    sel_base  = hit_base && !chain_i.base_seen;
    sel_nbase = hit_nbase && !chain_i.nbase_seen;
    sel_free  = is_free && !chain_i.free_seen;

    off     = addr_i - start_q;
    span    = CW'(off) + CW'(acc_size_i);
    lim     = CW'(size_q);
    in_here = used_q && (addr_i >= start_q) && (span <= lim);

    wr_en  = (ctl_i.rec_go && (ctl_i.any_base ? sel_base : sel_free)) ||
             (ctl_i.grow_go && (ctl_i.any_nbase ? sel_nbase : sel_base));
    clr_en = ctl_i.grow_go && ctl_i.any_nbase && sel_base && !sel_nbase;

    chain_o.base_seen  = chain_i.base_seen || hit_base;
    chain_o.nbase_seen = chain_i.nbase_seen || hit_nbase;
    chain_o.free_seen  = chain_i.free_seen || is_free;
    chain_o.in_seen    = chain_i.in_seen || in_here;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (wr_en) begin
      used_q <= 1'b1;
    end else if (clr_en) begin
      used_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_q <= wr_start_i;
      size_q  <= wr_size_i;
    end
  end

endmodule

>>> design/abt_move_cell.sv
// One relocation log entry with its local match, write and read-out logic.
module abt_move_cell #(
  parameter int unsigned ADDR_BITS = abt_pkg::ADDR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ADDR_BITS-1:0]   base_i,
  input  logic [ADDR_BITS-1:0]   nbase_i,
  input  abt_pkg::move_ctl_t     ctl_i,
  input  abt_pkg::move_chain_t   chain_i,
  input  logic [ADDR_BITS-1:0]   to_i,
  output abt_pkg::move_chain_t   chain_o,
  output logic [ADDR_BITS-1:0]   to_o
);
  import abt_pkg::*;

  logic [ADDR_BITS-1:0] from_q, to_q;
  logic                 used_q;
  logic                 hit, sel_hit, sel_free, wr_en;

  always_comb begin
    hit      = used_q && (from_q == base_i);
    sel_hit  = hit && !chain_i.hit_seen;
    sel_free = !used_q && !chain_i.free_seen;
    wr_en    = ctl_i.wr_go && (ctl_i.any_hit ? sel_hit : sel_free);

    chain_o.hit_seen  = chain_i.hit_seen || hit;
    chain_o.free_seen = chain_i.free_seen || !used_q;
    // Merge the first matching target into the passing data.
    to_o = to_i | (sel_hit ? to_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (wr_en) begin
      used_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      from_q <= base_i;
      to_q   <= nbase_i;
    end
  end

endmodule

>>> design/allocation_bounds_tracker.sv
// Top level of the allocation bounds tracker: region row, relocation row and control.
//
// For each command, the cycle that ends with the start transfer registers the
// command, the next cycle runs it through both rows of cells and writes the
// entries, and the result shows on the result ports for exactly one cycle
// after that, marked by done_o. busy is high only during the evaluation
// cycle, so a new command may be transferred while the previous result is on
// the ports. The critical path is the priority ripple through the
// REGION_ENTRIES region cells (and the MOVE_ENTRIES relocation cells), which
// picks the first matching or free entry. The receiver cannot hold
// results off: each result is transferred in the single cycle that done_o
// is high. The used flags of both tables clear at reset; there is no
// clearing pass.
module allocation_bounds_tracker #(
  parameter int unsigned REGION_ENTRIES = abt_pkg::REGION_ENTRIES_DEF,
  parameter int unsigned MOVE_ENTRIES   = abt_pkg::MOVE_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS      = abt_pkg::ADDR_BITS_DEF,
  parameter int unsigned SIZE_BITS      = abt_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action_i,
  input  logic [ADDR_BITS-1:0]              address_i,
  input  logic [ADDR_BITS-1:0]              base_i,
  input  logic [SIZE_BITS-1:0]              length_i,
  input  logic [ADDR_BITS-1:0]              new_base_i,
  output logic                              done_o,
  output logic                              valid_res_o,
  output logic [abt_pkg::OUT_ADDR_BITS-1:0] result_address_o,
  output logic [2:0]                        status_o
);
  import abt_pkg::*;

  localparam int unsigned CW = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 1;

  // Control state.
  fsm_e state_q, state_d;
  logic done_q;

  // Registered command.
  action_e              act_q;
  logic [ADDR_BITS-1:0] addr_q, base_q, nbase_q;
  logic [SIZE_BITS-1:0] len_q;

  // Registered result.
  logic                     valid_q, valid_d;
  logic [ADDR_BITS-1:0]     res_q, res_d;
  status_e                  status_q, status_d;

  // Cell rows.
  reg_chain_t           rchain [REGION_ENTRIES+1];
  move_chain_t          mchain [MOVE_ENTRIES+1];
  logic [ADDR_BITS-1:0] mto    [MOVE_ENTRIES+1];
  reg_ctl_t             rctl;
  move_ctl_t            mctl;

  logic                 evaluating;
  logic [SIZE_BITS-1:0] acc_size, wr_size;
  logic [ADDR_BITS-1:0] wr_start, offset, moved_addr;
  logic [CW-1:0]        needed;
  logic                 overflow, any_free, any_mfree;
  logic                 grow_ok;
  logic [ADDR_BITS+OUT_ADDR_BITS-1:0] res_ext;

  assign rchain[0] = '0;
  assign mchain[0] = '0;
  assign mto[0]    = '0;

  // Shared arithmetic on the held command.
  always_comb begin
    evaluating = (state_q == FSM_EVAL);
    acc_size   = (len_q == '0) ? SIZE_BITS'(1) : len_q;
    offset     = addr_q - base_q;
    needed     = CW'(offset) + CW'(len_q);
    overflow   = |needed[CW-1:SIZE_BITS];
    moved_addr = nbase_q + offset;
    wr_start   = (act_q == ACT_GROW) ? nbase_q : base_q;
    wr_size    = (act_q == ACT_GROW) ? needed[SIZE_BITS-1:0] : len_q;
    any_free   = rchain[REGION_ENTRIES].free_seen;
    any_mfree  = mchain[MOVE_ENTRIES].free_seen;

    grow_ok = (base_q != '0) && (addr_q != '0) && rchain[REGION_ENTRIES].base_seen &&
              (addr_q >= base_q) && !overflow && (nbase_q != '0) &&
              (mchain[MOVE_ENTRIES].hit_seen || any_mfree);

    rctl.rec_go    = evaluating && (act_q == ACT_RECORD) && (base_q != '0);
    rctl.grow_go   = evaluating && (act_q == ACT_GROW) && grow_ok;
    rctl.any_base  = rchain[REGION_ENTRIES].base_seen;
    rctl.any_nbase = rchain[REGION_ENTRIES].nbase_seen;

    mctl.wr_go   = rctl.grow_go;
    mctl.any_hit = mchain[MOVE_ENTRIES].hit_seen;
  end

  for (genvar g = 0; g < REGION_ENTRIES; g++) begin : g_region
    abt_region_cell #(
      .ADDR_BITS(ADDR_BITS),
      .SIZE_BITS(SIZE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .base_i     (base_q),
      .nbase_i    (nbase_q),
      .addr_i     (addr_q),
      .acc_size_i (acc_size),
      .wr_start_i (wr_start),
      .wr_size_i  (wr_size),
      .ctl_i      (rctl),
      .chain_i    (rchain[g]),
      .chain_o    (rchain[g+1])
    );
  end

  for (genvar g = 0; g < MOVE_ENTRIES; g++) begin : g_move
    abt_move_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .base_i  (base_q),
      .nbase_i (nbase_q),
      .ctl_i   (mctl),
      .chain_i (mchain[g]),
      .to_i    (mto[g]),
      .chain_o (mchain[g+1]),
      .to_o    (mto[g+1])
    );
  end

  // Sequence the command and build its result.
  always_comb begin
    state_d  = state_q;
    valid_d  = 1'b0;
    res_d    = '0;
    status_d = ST_OK;

    case (state_q)
      FSM_IDLE: begin
        if (start) begin
          state_d = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        state_d = FSM_IDLE;
        case (act_q)
          ACT_RECORD: begin
            if (base_q == '0) begin
              status_d = ST_NULL;
            end else if (!rctl.any_base && !any_free) begin
              status_d = ST_FULL;
            end else begin
              valid_d = 1'b1;
            end
          end
          ACT_CHECK: begin
            if (addr_q == '0) begin
              status_d = ST_NULL;
            end else begin
              valid_d = rchain[REGION_ENTRIES].in_seen;
            end
          end
          ACT_GROW: begin
            if ((base_q == '0) || (addr_q == '0)) begin
              status_d = ST_NULL;
            end else if (!rctl.any_base) begin
              status_d = ST_NOT_FOUND;
            end else if ((addr_q < base_q) || overflow) begin
              status_d = ST_BAD_OFFSET;
            end else if (nbase_q == '0) begin
              status_d = ST_ALLOC_FAIL;
            end else if (!mctl.any_hit && !any_mfree) begin
              status_d = ST_FULL;
            end else begin
              valid_d = 1'b1;
              res_d   = moved_addr;
            end
          end
          ACT_LOOKUP: begin
            valid_d = 1'b1;
            res_d   = mctl.any_hit ? mto[MOVE_ENTRIES] : base_q;
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= evaluating;
    end
  end

  // Hold the command while it evaluates.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      act_q   <= action_e'(action_i);
      addr_q  <= address_i;
      base_q  <= base_i;
      len_q   <= length_i;
      nbase_q <= new_base_i;
    end
  end

  // Hold the result for its single strobe cycle.
  always_ff @(posedge clk_i) begin
    if (evaluating) begin
      valid_q  <= valid_d;
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  assign res_ext          = {{OUT_ADDR_BITS{1'b0}}, res_q};
  assign busy             = evaluating;
  assign done_o           = done_q;
  assign valid_res_o      = valid_q;
  assign result_address_o = res_ext[OUT_ADDR_BITS-1:0];
  assign status_o         = status_q;

endmodule
